// ===== rtl/sce_pkg.sv =====
// ----------------------------------------------------------------------------
// sce_pkg
// Shared constants, types and lookup tables for the sigmoid cross-entropy block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sce_pkg;

	// table and fixed point set-up
	localparam int TABLE_DEPTH = 256;
	localparam int FRAC_BITS   = 8;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);

	// field widths
	localparam int LOGIT_W = 16;
	localparam int TGT_W   = 9;
	localparam int WGT_W   = 16;
	localparam int VAL_W   = 32;
	localparam int RECIP_W = 25;
	localparam int ACC_W   = 48;
	localparam int SIG_W   = 17;
	localparam int SP_W    = 16;
	localparam int IN_DATA_W = 48;
	localparam int CFG_IDX_W = 2;

	// fixed point ones
	localparam int ONE_Q16 = 65536;
	localparam int TGT_ONE = 256;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic {
		CMD_LOSS = 1'b0,
		CMD_GRAD = 1'b1
	} cmd_t;

	typedef enum logic {
		KIND_LOSS = 1'b0,
		KIND_GRAD = 1'b1
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NORMALIZE   = 2'd0,
		REG_RECIP_TOTAL = 2'd1,
		REG_RECIP_INST  = 2'd2
	} reg_idx_t;

	// one classified word as it travels through the queue
	typedef struct packed {
		cmd_t                      cmd;
		logic                      last;
		logic signed [LOGIT_W-1:0] logit;
		logic [TGT_W-1:0]          tgt;
		logic signed [WGT_W-1:0]   wgt;
		logic [SIG_W-1:0]          sig;
		logic [SP_W-1:0]           sp;
	} sce_item_t;

	typedef struct packed {
		logic              full;
		logic              empty;
		logic [QCNT_W-1:0] count;
	} sce_qstat_t;

	typedef logic [TABLE_DEPTH-1:0][SIG_W-1:0] sig_tab_t;
	typedef logic [TABLE_DEPTH-1:0][SP_W-1:0]  sp_tab_t;

	localparam longint ONE30  = longint'(1) << 30;
	localparam longint HALF30 = longint'(1) << 29;

	// shift-and-subtract quotient of two non-negative values, table build only
	function automatic longint udiv(input longint n, input longint d);
		longint q, r;
		int     b;
		q = 0;
		r = 0;
		for (b = 62; b >= 0; b--) begin
			r = (r <<< 1) | ((n >>> b) & longint'(1));
			if (r >= d) begin
				r = r - d;
				q = q | (longint'(1) <<< b);
			end
		end
		return q;
	endfunction

	// sigmoid and softplus at the midpoint of bin i, integer series in Q0.30
	function automatic logic [SIG_W+SP_W-1:0] tab_entry(input int i);
		longint v, t, e, den, z, z2, zp, s, sig, sp, k;
		v = (((2 * longint'(i) + 1) << 25) + TABLE_DEPTH / 2) / TABLE_DEPTH;
		t = ONE30;
		e = ONE30;
		for (k = 1; k <= 5; k++) begin
			t = udiv(((t * v + HALF30) >>> 30) + (k >>> 1), k);
			if (k[0])
				e = e - t;
			else
				e = e + t;
		end
		for (k = 0; k < 8; k++)
			e = (e * e + HALF30) >>> 30;
		den = ONE30 + e;
		sig = udiv((longint'(1) << 46) + (den >>> 1), den);
		z   = udiv(e <<< 30, 2 * ONE30 + e);
		z2  = (z * z + HALF30) >>> 30;
		zp  = z;
		s   = 0;
		for (k = 1; k <= 23; k += 2) begin
			s  = s + udiv(zp + (k >>> 1), k);
			zp = (zp * z2 + HALF30) >>> 30;
		end
		sp = (2 * s + (longint'(1) << 13)) >>> 14;
		return {sig[SIG_W-1:0], sp[SP_W-1:0]};
	endfunction

	function automatic sig_tab_t build_sig_tab();
		sig_tab_t                r;
		logic [SIG_W+SP_W-1:0]   ent;
		int                      i;
		for (i = 0; i < TABLE_DEPTH; i++) begin
			ent  = tab_entry(i);
			r[i] = ent[SIG_W+SP_W-1:SP_W];
		end
		return r;
	endfunction

	function automatic sp_tab_t build_sp_tab();
		sp_tab_t                 r;
		logic [SIG_W+SP_W-1:0]   ent;
		int                      i;
		for (i = 0; i < TABLE_DEPTH; i++) begin
			ent  = tab_entry(i);
			r[i] = ent[SP_W-1:0];
		end
		return r;
	endfunction

	localparam sig_tab_t SIG_TAB = build_sig_tab();
	localparam sp_tab_t  SP_TAB  = build_sp_tab();

endpackage

`default_nettype wire

// ===== rtl/sce_front.sv =====
// ----------------------------------------------------------------------------
// sce_front
// Input stage: unpacks a word, looks up sigmoid and softplus, queues it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sce_front
	import sce_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [IN_DATA_W-1:0] s_tdata,
	input  wire logic                 s_tuser,
	input  wire logic                 s_tlast,
	input  wire sce_qstat_t           qstat,
	output logic                      push,
	output sce_item_t                 push_item
);

	localparam int AX_W   = LOGIT_W + 1;
	localparam int PROD_W = AX_W + $clog2(TABLE_DEPTH + 1);

	logic signed [LOGIT_W-1:0] logit;
	logic [TGT_W-1:0]          tgt_raw;
	logic [TGT_W-1:0]          tgt;
	logic signed [WGT_W-1:0]   wgt;
	logic signed [AX_W-1:0]    x_ext;
	logic [AX_W-1:0]           ax;
	logic [PROD_W-1:0]         idx_full;
	logic                      in_tab;
	logic [IDX_W-1:0]          idx;
	logic [SIG_W-1:0]          sig_raw;
	logic [SIG_W-1:0]          sig_adj;
	logic [SP_W-1:0]           sp;
	logic                      accept;
	sce_item_t                 item_d;
	sce_item_t                 item_s1;
	logic                      vld_s1;

	assign logit   = s_tdata[LOGIT_W-1:0];
	assign tgt_raw = s_tdata[LOGIT_W+TGT_W-1:LOGIT_W];
	assign wgt     = s_tdata[LOGIT_W+TGT_W+WGT_W-1:LOGIT_W+TGT_W];

	always_comb begin
		x_ext    = AX_W'(logit);
		ax       = logit[LOGIT_W-1] ? AX_W'(-x_ext) : AX_W'(x_ext);
		idx_full = (PROD_W'(ax) * PROD_W'(TABLE_DEPTH)) >> (FRAC_BITS + 4);
		in_tab   = idx_full < PROD_W'(TABLE_DEPTH);
		idx      = idx_full[IDX_W-1:0];
		// beyond the table: sigmoid one, softplus zero
		sig_raw  = in_tab ? SIG_TAB[idx] : SIG_W'(ONE_Q16);
		sp       = in_tab ? SP_TAB[idx] : '0;
		sig_adj  = logit[LOGIT_W-1] ? SIG_W'(SIG_W'(ONE_Q16) - sig_raw) : sig_raw;
		tgt      = (tgt_raw > TGT_W'(TGT_ONE)) ? TGT_W'(TGT_ONE) : tgt_raw;

		item_d.cmd   = cmd_t'(s_tuser);
		item_d.last  = s_tlast;
		item_d.logit = logit;
		item_d.tgt   = tgt;
		item_d.wgt   = wgt;
		item_d.sig   = sig_adj;
		item_d.sp    = sp;
	end

	assign push     = vld_s1 && !qstat.full;
	assign s_tready = !vld_s1 || !qstat.full;
	assign accept   = s_tvalid && s_tready;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sce_queue.sv =====
// ----------------------------------------------------------------------------
// sce_queue
// Short flop queue that decouples the front stage from the back pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sce_queue
	import sce_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire sce_item_t push_item,
	input  wire logic      pop,
	output sce_item_t      head,
	output sce_qstat_t     qstat
);

	sce_item_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(p + 1'b1);
	endfunction

	assign head        = mem_q[rd_ptr_q];
	assign qstat.count = count_q;
	assign qstat.full  = count_q == QCNT_W'(QUEUE_DEPTH);
	assign qstat.empty = count_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sce_back.sv =====
// ----------------------------------------------------------------------------
// sce_back
// Arithmetic pipeline: element loss and gradient, accumulator, scaling
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sce_back
	import sce_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire sce_item_t          head,
	input  wire sce_qstat_t         qstat,
	output logic                    pop,
	input  wire logic [RECIP_W-1:0] recip,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [VAL_W-1:0]        m_tdata,
	output logic                    m_tuser
);

	localparam int D_W    = SIG_W + 1;
	localparam int DW_W   = D_W + WGT_W;
	localparam int TF_W   = TGT_W + 1;
	localparam int P_W    = LOGIT_W + TF_W;
	localparam int RSH    = (FRAC_BITS >= 8) ? FRAC_BITS - 8 : 0;
	localparam int LSH    = (FRAC_BITS < 8) ? 8 - FRAC_BITS : 0;
	localparam int EL_W   = 32;
	localparam int OP_W   = 24;
	localparam int PR_W   = OP_W + RECIP_W;
	localparam int WIDE_W = 64;
	localparam int GSH    = FRAC_BITS + 24;
	localparam logic [P_W-1:0] Q_RND = (P_W'(1) << RSH) >> 1;

	logic                        en;

	// stage 1: word taken from the queue
	sce_item_t                   item_s1;
	logic                        vld_s1;

	// stage 2: products
	logic signed [D_W-1:0]       d_c;
	logic signed [DW_W-1:0]      dw_c;
	logic signed [TF_W-1:0]      tfac_c;
	logic signed [P_W-1:0]       p_c;
	logic [P_W-1:0]              pmag_c;
	logic [P_W-1:0]              qmag_c;
	logic signed [EL_W-1:0]      q_c;
	logic signed [EL_W-1:0]      el_c;
	logic                        vld_s2;
	cmd_t                        cmd_s2;
	logic                        last_s2;
	logic signed [DW_W-1:0]      dw_s2;
	logic signed [EL_W-1:0]      el_s2;

	// stage 3: accumulate, split operand
	logic signed [ACC_W-1:0]     acc_q;
	logic signed [ACC_W:0]       acc_sum_c;
	logic signed [ACC_W-1:0]     acc_next_c;
	logic [DW_W-1:0]             gmag_c;
	logic [ACC_W-1:0]            lmag_c;
	logic                        vld_s3;
	logic                        res_s3;
	kind_t                       kind_s3;
	logic                        neg_s3;
	logic [OP_W-1:0]             hi_s3;
	logic [OP_W-1:0]             lo_s3;

	// stage 4: scaling products
	logic                        vld_s4;
	logic                        res_s4;
	kind_t                       kind_s4;
	logic                        neg_s4;
	logic [PR_W-1:0]             ph_s4;
	logic [PR_W-1:0]             pl_s4;

	// output word
	logic [WIDE_W-1:0]           gfull_c;
	logic [WIDE_W-1:0]           gres_c;
	logic [WIDE_W-1:0]           lres_c;
	logic [WIDE_W-1:0]           mag_c;
	logic [VAL_W-1:0]            val_c;
	logic                        out_vld_q;
	logic [VAL_W-1:0]            out_val_q;
	kind_t                       out_kind_q;

	assign en  = !out_vld_q || m_tready;
	assign pop = en && !qstat.empty;

	// element terms
	always_comb begin
		d_c    = D_W'(signed'({1'b0, item_s1.sig})) -
		         D_W'(signed'({1'b0, item_s1.tgt, 8'b0}));
		dw_c   = d_c * item_s1.wgt;
		tfac_c = TF_W'(signed'({1'b0, item_s1.tgt})) -
		         (item_s1.logit[LOGIT_W-1] ? TF_W'(0) : TF_W'(TGT_ONE));
		p_c    = item_s1.logit * tfac_c;
		// bring the product to 16 fraction bits, rounding half away from zero
		pmag_c = p_c[P_W-1] ? P_W'(-p_c) : P_W'(p_c);
		qmag_c = (pmag_c + Q_RND) >> RSH;
		q_c    = p_c[P_W-1] ? -EL_W'(qmag_c) : EL_W'(qmag_c);
		q_c    = q_c <<< LSH;
		el_c   = EL_W'(item_s1.sp) - q_c;
	end

	// saturating accumulator and operand split
	always_comb begin
		acc_sum_c = (ACC_W+1)'(acc_q) + (ACC_W+1)'(el_s2);
		if (acc_sum_c[ACC_W] != acc_sum_c[ACC_W-1])
			acc_next_c = acc_sum_c[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} :
			                                {1'b0, {(ACC_W-1){1'b1}}};
		else
			acc_next_c = acc_sum_c[ACC_W-1:0];
		gmag_c = dw_s2[DW_W-1] ? DW_W'(-dw_s2) : DW_W'(dw_s2);
		lmag_c = acc_next_c[ACC_W-1] ? ACC_W'(-acc_next_c) : ACC_W'(acc_next_c);
	end

	// final rounding and saturation
	always_comb begin
		gfull_c = (WIDE_W'(ph_s4) << 16) + WIDE_W'(pl_s4);
		gres_c  = (gfull_c + (WIDE_W'(1) << (GSH - 1))) >> GSH;
		lres_c  = WIDE_W'(ph_s4) + ((WIDE_W'(pl_s4) + (WIDE_W'(1) << 23)) >> 24);
		mag_c   = (kind_s4 == KIND_GRAD) ? gres_c : lres_c;
		if (neg_s4) begin
			if (mag_c > WIDE_W'(64'h8000_0000))
				val_c = 32'h8000_0000;
			else
				val_c = VAL_W'(-mag_c[VAL_W-1:0]);
		end else begin
			if (mag_c > WIDE_W'(64'h7FFF_FFFF))
				val_c = 32'h7FFF_FFFF;
			else
				val_c = mag_c[VAL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			out_vld_q <= 1'b0;
			acc_q     <= '0;
		end else if (en) begin
			vld_s1    <= pop;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			out_vld_q <= vld_s4 && res_s4;
			if (vld_s2 && cmd_s2 == CMD_LOSS)
				acc_q <= last_s2 ? '0 : acc_next_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (pop)
				item_s1 <= head;

			cmd_s2  <= item_s1.cmd;
			last_s2 <= item_s1.last;
			dw_s2   <= dw_c;
			el_s2   <= el_c;

			if (cmd_s2 == CMD_GRAD) begin
				kind_s3 <= KIND_GRAD;
				res_s3  <= 1'b1;
				neg_s3  <= dw_s2[DW_W-1];
				hi_s3   <= OP_W'(gmag_c >> 16);
				lo_s3   <= OP_W'(gmag_c[15:0]);
			end else begin
				kind_s3 <= KIND_LOSS;
				res_s3  <= last_s2;
				neg_s3  <= acc_next_c[ACC_W-1];
				hi_s3   <= lmag_c[ACC_W-1:OP_W];
				lo_s3   <= lmag_c[OP_W-1:0];
			end

			kind_s4 <= kind_s3;
			res_s4  <= res_s3;
			neg_s4  <= neg_s3;
			ph_s4   <= PR_W'(hi_s3) * PR_W'(recip);
			pl_s4   <= PR_W'(lo_s3) * PR_W'(recip);

			out_val_q  <= val_c;
			out_kind_q <= kind_s4;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_val_q;
	assign m_tuser  = out_kind_q;

endmodule

`default_nettype wire

// ===== rtl/sigmoid_cross_entropy_loss_top.sv =====
// ----------------------------------------------------------------------------
// sigmoid_cross_entropy_loss_top
// Streams logit/target words; in loss mode it sums the stable per-element
// cross-entropy and emits the scaled instance loss on the last word, in
// gradient mode it emits (sigmoid(x) - t) * upstream * reciprocal per word.
// Inputs are signed Q7.8, results saturated signed Q15.16. A front stage
// unpacks each word and reads sigmoid/softplus from constant tables, a
// four-entry queue follows, and a five-register back pipeline does the
// products, the 48-bit saturating accumulator and the final rounding. With
// m_tready held high the block takes one word per clock. The back pipeline
// moves as one and halts while a result waits on m_tready, so throughput is
// then set by the output side; the front and queue keep taking up to five
// more words meanwhile. The only feedback is the accumulator add. The user
// must write the registers through the cfg port only while no word is in
// flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sigmoid_cross_entropy_loss_top
	import sce_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// input words
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [IN_DATA_W-1:0] s_tdata,   // logit, target_prob, upstream_weight, pad
	input  wire logic                 s_tuser,   // command
	input  wire logic                 s_tlast,   // last_element
	// result words
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [VAL_W-1:0]          m_tdata,   // value
	output logic                      m_tuser,   // result_kind
	// register writes
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [RECIP_W-1:0]   cfg_data
);

	// configuration registers
	logic               norm_q;
	logic [RECIP_W-1:0] recip_total_q;
	logic [RECIP_W-1:0] recip_inst_q;
	logic [RECIP_W-1:0] recip;

	// front to queue to back
	logic               q_push;
	sce_item_t          q_push_item;
	logic               q_pop;
	sce_item_t          q_head;
	sce_qstat_t         qstat;

	// register file: plain indexed writes, unused index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			norm_q        <= 1'b0;
			recip_total_q <= RECIP_W'(25'h100_0000);
			recip_inst_q  <= RECIP_W'(25'h100_0000);
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_NORMALIZE:   norm_q        <= cfg_data[0];
				REG_RECIP_TOTAL: recip_total_q <= cfg_data;
				REG_RECIP_INST:  recip_inst_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// normalise by total element count or by instance count
	assign recip = norm_q ? recip_total_q : recip_inst_q;

	sce_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.qstat     (qstat),
		.push      (q_push),
		.push_item (q_push_item)
	);

	sce_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_push_item),
		.pop       (q_pop),
		.head      (q_head),
		.qstat     (qstat)
	);

	sce_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (q_head),
		.qstat    (qstat),
		.pop      (q_pop),
		.recip    (recip),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// the front never writes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && qstat.full))
		else $error("queue written while full");

	// the back never reads an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_pop && qstat.empty))
		else $error("queue read while empty");

	// input back-pressure only comes from a full queue
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> qstat.full)
		else $error("input stalled with room in queue");

	// fill count stays within the queue depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.count <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count out of range");

endmodule

`default_nettype wire
